// ----- rtl/trc_pkg.sv -----
// Shared types and constants for the trace event ring.
// Used by trc_ctrl, trc_dpath and trace_event_ring_with_drop_count.
`default_nettype none

package trc_pkg;

  localparam int RING_DEPTH_DEF = 1024;
  localparam int MAX_BURST_DEF  = 64;
  localparam int BURST_W        = 7;
  localparam int CNT_W          = 32;

  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_DRAIN  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [2:0] KIND_RECORDED = 3'd0;
  localparam logic [2:0] KIND_DROPPED  = 3'd1;
  localparam logic [2:0] KIND_ENTRY    = 3'd2;
  localparam logic [2:0] KIND_EMPTY    = 3'd3;
  localparam logic [2:0] KIND_CLEARED  = 3'd4;

  typedef struct packed {
    logic [1:0]         op;
    logic [7:0]         slot;
    logic [63:0]        handle;
    logic [31:0]        arg_a;
    logic [31:0]        arg_b;
    logic [31:0]        arg_c;
    logic [63:0]        time_us;
    logic [BURST_W-1:0] drain_max;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [63:0]      ev_time;
    logic [7:0]       ev_slot;
    logic [63:0]      ev_handle;
    logic [31:0]      ev_a;
    logic [31:0]      ev_b;
    logic [31:0]      ev_c;
    logic             last;
    logic [CNT_W-1:0] recorded_total;
    logic [CNT_W-1:0] dropped_total;
    logic             half_full;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic       write;
    logic       drop;
    logic       read;
    logic       clear;
    logic       emit;
    logic [2:0] kind;
    logic       last;
  } dp_cmd_t;

  // Datapath to controller. occ_sat is occupancy capped at the burst limit.
  typedef struct packed {
    logic               empty;
    logic               full;
    logic [BURST_W-1:0] occ_sat;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/trc_ctrl.sv -----
// Controller FSM for the trace event ring: decodes beats, sequences drains.
// Depends on trc_pkg.
`default_nettype none

module trc_ctrl
  import trc_pkg::*;
#(
  parameter int MAX_BURST = MAX_BURST_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [1:0] op,
  input  wire logic [BURST_W-1:0] drain_max,
  input  wire dp_status_t status,
  output logic            busy,
  output dp_cmd_t         cmd
);

  localparam int BW = $clog2(MAX_BURST + 1);
  localparam logic [BURST_W-1:0] BURST_LIM = BURST_W'(MAX_BURST);

  typedef enum logic {S_IDLE, S_DRAIN} state_t;

  state_t           state_r, state_nxt;
  logic [BW-1:0]    remain_r, remain_nxt;
  logic [BURST_W-1:0] want, take;
  logic             accept;

  assign busy   = (state_r == S_DRAIN);
  assign accept = start && !busy;

  // Clamp request, then to what is in the ring.
  assign want = (drain_max > BURST_LIM) ? BURST_LIM : drain_max;
  assign take = (status.occ_sat < want) ? status.occ_sat : want;

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    remain_nxt = remain_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_RECORD: begin
              cmd.emit = 1'b1;
              cmd.last = 1'b1;
              if (status.full) begin
                cmd.drop = 1'b1;
                cmd.kind = KIND_DROPPED;
              end else begin
                cmd.write = 1'b1;
                cmd.kind  = KIND_RECORDED;
              end
            end
            OP_DRAIN: begin
              if (want != '0) begin
                cmd.emit = 1'b1;
                if (status.empty) begin
                  cmd.kind = KIND_EMPTY;
                  cmd.last = 1'b1;
                end else begin
                  cmd.read   = 1'b1;
                  cmd.kind   = KIND_ENTRY;
                  cmd.last   = (take == BURST_W'(1));
                  remain_nxt = BW'(take - BURST_W'(1));
                  if (take != BURST_W'(1)) begin
                    state_nxt = S_DRAIN;
                  end
                end
              end
            end
            OP_CLEAR: begin
              cmd.clear = 1'b1;
              cmd.emit  = 1'b1;
              cmd.kind  = KIND_CLEARED;
              cmd.last  = 1'b1;
            end
            default: begin
              // unused opcode: no result
            end
          endcase
        end
      end
      S_DRAIN: begin
        // pop one entry a cycle until the burst is done
        cmd.read   = 1'b1;
        cmd.emit   = 1'b1;
        cmd.kind   = KIND_ENTRY;
        cmd.last   = (remain_r == BW'(1));
        remain_nxt = remain_r - BW'(1);
        if (remain_r == BW'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      remain_r <= '0;
    end else begin
      state_r  <= state_nxt;
      remain_r <= remain_nxt;
    end
  end

`ifndef SYNTHESIS
  a_drain_pops: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (cmd.read && cmd.emit && (cmd.kind == KIND_ENTRY)))
    else $error("drain cycle without a pop");

  a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.read && cmd.last) |=> !busy)
    else $error("busy held after final drained entry");

  a_remain_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (remain_r != '0))
    else $error("drain in progress with nothing left");
`endif

endmodule

`default_nettype wire

// ----- rtl/trc_dpath.sv -----
// Datapath for the trace event ring: entry memory, pointers, counters, result register.
// Depends on trc_pkg; driven by commands from trc_ctrl.
`default_nettype none

module trc_dpath
  import trc_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int MAX_BURST  = MAX_BURST_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire dp_cmd_t  cmd,
  input  wire in_item_t in_data,
  output dp_status_t    status,
  output logic          out_valid,
  output out_item_t     out_data
);

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int PW = $clog2(2 * RING_DEPTH);
  localparam int CW = (PW > BURST_W) ? PW : BURST_W;
  localparam logic [PW-1:0] DEPTH_P   = PW'(RING_DEPTH);
  localparam logic [PW-1:0] HALF_P    = PW'(RING_DEPTH / 2);
  localparam logic [PW-1:0] SPAN_LAST = PW'(2 * RING_DEPTH - 1);
  localparam logic [PW:0]   SPAN_X    = (PW + 1)'(2 * RING_DEPTH);
  localparam logic [CW-1:0] BURST_X   = CW'(MAX_BURST);
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic [63:0] time_us;
    logic [7:0]  slot;
    logic [63:0] handle;
    logic [31:0] arg_a;
    logic [31:0] arg_b;
    logic [31:0] arg_c;
  } entry_t;

  entry_t mem [RING_DEPTH];
  entry_t rd_q_r, wr_entry;

  logic [PW-1:0]    wr_ptr_r, rd_ptr_r, occ;
  logic [AW-1:0]    wpos, rpos;
  logic [CW-1:0]    occ_x;
  logic [CNT_W-1:0] rec_cnt_r, drop_cnt_r;
  logic             out_valid_r, last_r;
  logic [2:0]       kind_r;

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
    return (p == SPAN_LAST) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [AW-1:0] position(input logic [PW-1:0] p);
    logic [PW-1:0] d;
    d = p - DEPTH_P;
    return (p >= DEPTH_P) ? d[AW-1:0] : p[AW-1:0];
  endfunction

  assign wpos = position(wr_ptr_r);
  assign rpos = position(rd_ptr_r);

  always_comb begin
    logic [PW:0] wrap;
    wrap = {1'b0, wr_ptr_r} + SPAN_X - {1'b0, rd_ptr_r};
    occ  = (wr_ptr_r >= rd_ptr_r) ? (wr_ptr_r - rd_ptr_r) : wrap[PW-1:0];
  end

  assign occ_x          = CW'(occ);
  assign status.empty   = (occ == '0);
  assign status.full    = (occ >= DEPTH_P);
  assign status.occ_sat = (occ_x >= BURST_X) ? BURST_W'(MAX_BURST) : BURST_W'(occ_x);

  assign wr_entry = '{time_us: in_data.time_us, slot: in_data.slot,
                      handle: in_data.handle, arg_a: in_data.arg_a,
                      arg_b: in_data.arg_b, arg_c: in_data.arg_c};

  // entry store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[wpos] <= wr_entry;
    end
    if (cmd.read) begin
      rd_q_r <= mem[rpos];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      rec_cnt_r   <= '0;
      drop_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.clear) begin
        wr_ptr_r   <= '0;
        rd_ptr_r   <= '0;
        rec_cnt_r  <= '0;
        drop_cnt_r <= '0;
      end else begin
        if (cmd.write) begin
          wr_ptr_r <= advance(wr_ptr_r);
          if (rec_cnt_r != CNT_MAX) begin
            rec_cnt_r <= rec_cnt_r + CNT_W'(1);
          end
        end
        if (cmd.drop && (drop_cnt_r != CNT_MAX)) begin
          drop_cnt_r <= drop_cnt_r + CNT_W'(1);
        end
        if (cmd.read) begin
          rd_ptr_r <= advance(rd_ptr_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= cmd.kind;
    last_r <= cmd.last;
  end

  // Counters and pointers already hold the post-update state here.
  always_comb begin
    logic is_entry;
    is_entry                = (kind_r == KIND_ENTRY);
    out_data.kind           = kind_r;
    out_data.ev_time        = is_entry ? rd_q_r.time_us : '0;
    out_data.ev_slot        = is_entry ? rd_q_r.slot    : '0;
    out_data.ev_handle      = is_entry ? rd_q_r.handle  : '0;
    out_data.ev_a           = is_entry ? rd_q_r.arg_a   : '0;
    out_data.ev_b           = is_entry ? rd_q_r.arg_b   : '0;
    out_data.ev_c           = is_entry ? rd_q_r.arg_c   : '0;
    out_data.last           = last_r;
    out_data.recorded_total = rec_cnt_r;
    out_data.dropped_total  = drop_cnt_r;
    out_data.half_full      = (occ >= HALF_P);
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ <= DEPTH_P)
    else $error("ring occupancy above depth");

  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |-> !status.full)
    else $error("write into a full ring");

  a_no_read_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.read |-> !status.empty)
    else $error("read from an empty ring");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (rec_cnt_r == '0 && drop_cnt_r == '0 && occ == '0))
    else $error("state not zero after clear");
`endif

endmodule

`default_nettype wire

// ----- rtl/trace_event_ring_with_drop_count.sv -----
// Top level of the trace event ring with drop counter.
// Depends on trc_pkg, trc_ctrl and trc_dpath.
//
//   channel  ports                     handshake
//   -------  ------------------------  ----------------------------------
//   input    start, busy, in_data      beat taken when start && !busy
//   result   out_valid, out_data       beat shown one cycle, always taken
//
// A record or clear beat leaves busy low; a new beat may follow in the
// next cycle, and its result shows on the cycle after it is taken.
// A drain of n entries (n = min(drain_max, MAX_BURST, occupancy)) pops
// them through the single read port of the entry memory, one entry a
// cycle, and busy stays high until the last entry has been popped.
// Reset is synchronous, active low; it empties the ring and zeroes both
// counters at once. Entry contents are left as they are.
// The receiver cannot stall: every result is on the ports exactly one cycle.
`default_nettype none

module trace_event_ring_with_drop_count
  import trc_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int MAX_BURST  = MAX_BURST_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t in_data,
  output logic          out_valid,
  output out_item_t     out_data
);

  // command and status between controller and datapath
  dp_cmd_t    cmd;
  dp_status_t status;

  // Decode the beat, decide record versus drop, and sequence drain bursts.
  trc_ctrl #(
    .MAX_BURST (MAX_BURST)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .op        (in_data.op),
    .drain_max (in_data.drain_max),
    .status    (status),
    .busy      (busy),
    .cmd       (cmd)
  );

  // Hold entries, pointers and saturating counters; register each result.
  trc_dpath #(
    .RING_DEPTH (RING_DEPTH),
    .MAX_BURST  (MAX_BURST)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- dv/trace_ring_checker.sv -----
`timescale 1ns / 1ps
// Checker for the trace event ring: follows input and result beats, keeps its own
// ring model, and compares every result beat field by field. Depends on trc_pkg.
module trace_ring_checker
  import trc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire logic      busy,
  input  wire in_item_t  in_data,
  input  wire logic      out_valid,
  input  wire out_item_t out_data,
  output int             errors,
  output int             pending
);

  localparam int DEPTH = RING_DEPTH_DEF;
  localparam int IDX_W = $clog2(2 * DEPTH);

  in_item_t         ring_mem [DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] rec_cnt;
  logic [CNT_W-1:0] drop_cnt;
  out_item_t        expected_results [$];
  out_item_t        oldest;

  function automatic logic [IDX_W-1:0] fill_level();
    return wr_ptr - rd_ptr;
  endfunction

  // Counters and half-full flag as they stand now; payload fields zero.
  function automatic out_item_t status_word(logic [2:0] kind, logic last);
    out_item_t r;
    r = '0;
    r.kind           = kind;
    r.last           = last;
    r.recorded_total = rec_cnt;
    r.dropped_total  = drop_cnt;
    r.half_full      = (fill_level() >= DEPTH / 2);
    return r;
  endfunction

  task automatic predict_ring_beat(in_item_t b);
    int        want;
    int        take;
    out_item_t r;
    in_item_t  e;
    case (b.op)
      OP_RECORD: begin
        if (fill_level() >= DEPTH) begin
          if (drop_cnt != '1) drop_cnt++;
          expected_results.push_back(status_word(KIND_DROPPED, 1'b1));
        end else begin
          ring_mem[wr_ptr[IDX_W-2:0]] = b;
          wr_ptr++;
          if (rec_cnt != '1) rec_cnt++;
          expected_results.push_back(status_word(KIND_RECORDED, 1'b1));
        end
      end
      OP_DRAIN: begin
        want = int'(b.drain_max);
        if (want > MAX_BURST_DEF) want = MAX_BURST_DEF;
        if (want != 0) begin
          if (fill_level() == 0) begin
            expected_results.push_back(status_word(KIND_EMPTY, 1'b1));
          end else begin
            take = (int'(fill_level()) < want) ? int'(fill_level()) : want;
            for (int k = 0; k < take; k++) begin
              e = ring_mem[rd_ptr[IDX_W-2:0]];
              rd_ptr++;
              // status after this entry has been popped
              r = status_word(KIND_ENTRY, k == take - 1);
              r.ev_time   = e.time_us;
              r.ev_slot   = e.slot;
              r.ev_handle = e.handle;
              r.ev_a      = e.arg_a;
              r.ev_b      = e.arg_b;
              r.ev_c      = e.arg_c;
              expected_results.push_back(r);
            end
          end
        end
      end
      OP_CLEAR: begin
        wr_ptr   = '0;
        rd_ptr   = '0;
        rec_cnt  = '0;
        drop_cnt = '0;
        expected_results.push_back(status_word(KIND_CLEARED, 1'b1));
      end
      default: ;
    endcase
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns %s: expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr   = '0;
      rd_ptr   = '0;
      rec_cnt  = '0;
      drop_cnt = '0;
      expected_results.delete();
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns unexpected result: expected none actual %h", $time, out_data);
          errors++;
        end else begin
          oldest = expected_results.pop_front();
          check_field("kind", 64'(oldest.kind), 64'(out_data.kind));
          check_field("ev_time", oldest.ev_time, out_data.ev_time);
          check_field("ev_slot", 64'(oldest.ev_slot), 64'(out_data.ev_slot));
          check_field("ev_handle", oldest.ev_handle, out_data.ev_handle);
          check_field("ev_a", 64'(oldest.ev_a), 64'(out_data.ev_a));
          check_field("ev_b", 64'(oldest.ev_b), 64'(out_data.ev_b));
          check_field("ev_c", 64'(oldest.ev_c), 64'(out_data.ev_c));
          check_field("last", 64'(oldest.last), 64'(out_data.last));
          check_field("recorded_total", 64'(oldest.recorded_total),
                      64'(out_data.recorded_total));
          check_field("dropped_total", 64'(oldest.dropped_total),
                      64'(out_data.dropped_total));
          check_field("half_full", 64'(oldest.half_full), 64'(out_data.half_full));
        end
      end
      if (start && !busy) predict_ring_beat(in_data);
    end
    pending = expected_results.size();
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Top of the trace event ring testbench: clock, reset, stimulus and verdict.
// Depends on trc_pkg, trace_event_ring_with_drop_count and trace_ring_checker.
module testbench;
  import trc_pkg::*;

  // op code the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int LIMIT_CYCLES = 200000;
  // a full drain burst plus margin
  localparam int TAIL_CYCLES  = 2 * MAX_BURST_DEF + 16;

  logic      clk;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_data = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_data;
  int        errors;
  int        pending;
  int        idle_pct    = 0;
  int        cycle_count = 0;

  trace_event_ring_with_drop_count DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  trace_ring_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .errors   (errors),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop: a run that reaches LIMIT_CYCLES is reported as a mismatch.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Random payload for any op; drain_max is given by the caller.
  function automatic in_item_t rand_beat(logic [1:0] op, logic [BURST_W-1:0] dmax);
    in_item_t b;
    b.op        = op;
    b.slot      = 8'($urandom);
    b.handle    = {$urandom, $urandom};
    b.arg_a     = $urandom;
    b.arg_b     = $urandom;
    b.arg_c     = $urandom;
    b.time_us   = {$urandom, $urandom};
    b.drain_max = dmax;
    return b;
  endfunction

  // Mostly short drains, with zero, full-burst and oversized requests mixed in.
  function automatic logic [BURST_W-1:0] rand_drain_len();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) return '0;
    if (pick < 20) return BURST_W'($urandom_range(127, MAX_BURST_DEF + 1));
    if (pick < 30) return BURST_W'(MAX_BURST_DEF);
    return BURST_W'($urandom_range(8, 1));
  endfunction

  // Present one beat and hold it until the block takes it. Idle cycles go
  // in front of the beat; start stays high across back-to-back beats.
  task automatic send_beat(in_item_t b);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    in_data <= b;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // Hold the sender off until every predicted result has come out.
  // pending is sampled on the falling edge, away from the checker update.
  task automatic wait_ring_idle();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Random traffic: record bursts dominate so the ring keeps some depth,
  // drains of varied length pull it back, clears and unused ops are rare.
  task automatic random_mix(int count);
    int pick;
    int burst;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        burst = $urandom_range(6, 1);
        repeat (burst) send_beat(rand_beat(OP_RECORD, BURST_W'($urandom)));
      end else if (pick < 85) begin
        send_beat(rand_beat(OP_DRAIN, rand_drain_len()));
      end else if (pick < 92) begin
        send_beat(rand_beat(OP_CLEAR, BURST_W'($urandom)));
      end else begin
        send_beat(rand_beat(OP_UNUSED, BURST_W'($urandom)));
      end
    end
  endtask

  initial begin
    in_item_t b;

    // Hold reset low, then release it on a rising edge.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Phase one: idle_pct is 29, the percent odds of each idle before a beat.
    idle_pct = 29;

    // Drain on an empty ring, then a drain that asks for nothing.
    send_beat(rand_beat(OP_DRAIN, BURST_W'(5)));
    send_beat(rand_beat(OP_DRAIN, '0));

    // Record with every payload bit low, then with every payload bit high.
    b = '0;
    b.op = OP_RECORD;
    send_beat(b);
    b = '1;
    b.op = OP_RECORD;
    send_beat(b);
    repeat (3) send_beat(rand_beat(OP_RECORD, '1));

    // Partial drain, oversized drain that empties the ring, then empty again.
    send_beat(rand_beat(OP_DRAIN, BURST_W'(2)));
    send_beat(rand_beat(OP_DRAIN, '1));
    send_beat(rand_beat(OP_DRAIN, BURST_W'(MAX_BURST_DEF)));

    // Unused op must leave no trace.
    send_beat(rand_beat(OP_UNUSED, '1));

    // Clear with entries pending, then drain the emptied ring.
    repeat (2) send_beat(rand_beat(OP_RECORD, '0));
    send_beat(rand_beat(OP_CLEAR, '1));
    send_beat(rand_beat(OP_DRAIN, BURST_W'(1)));

    wait_ring_idle();
    random_mix(12);

    // Phase two: idle_pct is 66, the percent odds of each idle before a beat.
    // Build some depth, pull it with a full-size request, then drain out.
    idle_pct = 66;
    send_beat(rand_beat(OP_CLEAR, '0));
    repeat (20) send_beat(rand_beat(OP_RECORD, BURST_W'($urandom)));
    send_beat(rand_beat(OP_DRAIN, BURST_W'(MAX_BURST_DEF)));
    repeat (2) send_beat(rand_beat(OP_RECORD, BURST_W'($urandom)));
    repeat (3) send_beat(rand_beat(OP_DRAIN, '1));
    random_mix(8);
    wait_ring_idle();

    // Phase three: no idling at all, back-to-back beats.
    idle_pct = 0;
    random_mix(12);
    send_beat(rand_beat(OP_DRAIN, '1));

    // Drop start, let the ring drain out, then a tail for stray beats.
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/trc_pkg.sv
rtl/trc_ctrl.sv
rtl/trc_dpath.sv
rtl/trace_event_ring_with_drop_count.sv
dv/trace_ring_checker.sv
dv/testbench.sv
